// ===== sv/nrpa_pkg.sv =====
// Shared types and constants for the nearest reference point attractor.
// Used by the search cells, the best-distance tracker, the result unit and the top level.
package nrpa_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = 25;
  localparam int SqW    = 48;
  localparam int GainW  = 16;
  localparam int ProdW  = DiffW + GainW;
  localparam int CompW  = 3;
  localparam int IdxW   = 8;

  localparam logic signed [GainW-1:0] GAIN_RESET = 16'sd256;
  localparam logic signed [CoordW-1:0] SAT_HI = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] SAT_LO = 24'sh800000;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Marker bits of a token travelling along the cell chain.
  typedef struct packed {
    logic vld;
    logic fetch;
    logic last;
  } ctl_t;

  // One axis of the result vector handed to the output unit.
  typedef struct packed {
    logic                    vld;
    logic [CompW-1:0]        comp;
    logic signed [DiffW-1:0] diff;
    logic [IdxW-1:0]         nearest;
    logic                    empty;
    logic                    last;
  } emit_req_t;

endpackage

// ===== sv/nearest_reference_point_attractor.sv =====
// Nearest reference point attractor. Reference points are loaded one coordinate
// per request into a chain of DIM cells, one cell per axis, each with its own
// MAX_POINTS-word memory. Load, clear and non-final query requests are taken one
// per cycle. A final query request on an empty table goes straight to the
// results, which are zero and flagged empty; otherwise it starts a scan: one
// point enters the chain per cycle and each cell reads its memory, squares the
// axis difference and adds it to the running distance in registered steps. A
// second token then runs down the chain to pick up the winning point's
// differences, after which the DIM results follow one per cycle while
// out_tready stays high. No request is accepted during a search.
// Depends on nrpa_pkg, nrpa_cell, nrpa_best and nrpa_emit.
module nearest_reference_point_attractor #(
  parameter int MAX_POINTS = 256,
  parameter int DIM        = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // point_index, component, coord_value
  input  logic [1:0]  in_tuser,   // cmd
  input  logic        in_tlast,   // last_component
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_component, attract_value, nearest_index
  output logic        out_tuser,  // table_empty
  output logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // field_gain
);
  import nrpa_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int SW = SqW + $clog2(DIM);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_WAIT  = 5'b00100,
    S_FETCH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [IW-1:0]           feed_r, feed_nxt;
  ctl_t                    inj_ctl_r, inj_ctl_nxt;
  logic [IW-1:0]           inj_addr_r, inj_addr_nxt;
  logic                    empty_r, empty_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic signed [GainW-1:0] gain_r;

  logic                     in_fire;
  cmd_t                     cmd;
  logic [IdxW-1:0]          idx;
  logic [CompW-1:0]         comp;
  logic signed [CoordW-1:0] val;
  logic                     load_ok;
  logic [CW-1:0]            idx_p1;
  logic                     scan_last;

  ctl_t                    ctl_c  [DIM+1];
  logic [IW-1:0]           addr_c [DIM+1];
  logic [SW-1:0]           sum_c  [DIM+1];
  logic signed [DiffW-1:0] diffs  [DIM];

  logic [IW-1:0] best_idx;
  logic          best_done;
  emit_req_t     req;
  logic          req_ready;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign idx       = in_tdata[7:0];
  assign comp      = in_tdata[10:8];
  assign val       = in_tdata[34:11];
  assign load_ok   = in_fire && (cmd == CMD_LOAD) && (32'(idx) < MAX_POINTS)
                     && (32'(comp) < DIM);
  assign idx_p1    = CW'(9'(idx) + 9'd1);
  assign scan_last = (CW'(feed_r) + CW'(1)) == count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_data;
    end
  end

  assign ctl_c[0]  = inj_ctl_r;
  assign addr_c[0] = inj_addr_r;
  assign sum_c[0]  = '0;

  for (genvar g = 0; g < DIM; g++) begin : g_cell
    nrpa_cell #(
      .DEPTH (MAX_POINTS),
      .IW    (IW),
      .SW    (SW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (load_ok && (comp == CompW'(g))),
      .wr_addr (IW'(idx)),
      .wr_data (val),
      .q_en    (in_fire && (cmd == CMD_QUERY) && (comp == CompW'(g))),
      .ctl_i   (ctl_c[g]),
      .addr_i  (addr_c[g]),
      .sum_i   (sum_c[g]),
      .ctl_o   (ctl_c[g+1]),
      .addr_o  (addr_c[g+1]),
      .sum_o   (sum_c[g+1]),
      .diff_o  (diffs[g])
    );
  end

  nrpa_best #(
    .IW (IW),
    .SW (SW)
  ) u_best (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl_c[DIM]),
    .addr_i     (addr_c[DIM]),
    .sum_i      (sum_c[DIM]),
    .best_idx_o (best_idx),
    .done_o     (best_done)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    feed_nxt     = feed_r;
    inj_ctl_nxt  = '0;
    inj_addr_nxt = inj_addr_r;
    empty_nxt    = empty_r;
    k_nxt        = k_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_LOAD: begin
              if (load_ok && in_tlast && (idx_p1 > count_r)) begin
                count_nxt = idx_p1;
              end
            end
            CMD_QUERY: begin
              if (in_tlast) begin
                if (count_r == '0) begin
                  empty_nxt = 1'b1;
                  k_nxt     = '0;
                  state_nxt = S_EMIT;
                end else begin
                  empty_nxt = 1'b0;
                  feed_nxt  = '0;
                  state_nxt = S_SCAN;
                end
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        inj_ctl_nxt.vld  = 1'b1;
        inj_ctl_nxt.last = scan_last;
        inj_addr_nxt     = feed_r;
        feed_nxt         = feed_r + IW'(1);
        if (scan_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // Send one more token down the chain so every cell latches the
        // difference of the winning point on its own axis.
        if (best_done) begin
          inj_ctl_nxt.vld   = 1'b1;
          inj_ctl_nxt.fetch = 1'b1;
          inj_addr_nxt      = best_idx;
          state_nxt         = S_FETCH;
        end
      end
      S_FETCH: begin
        if (ctl_c[DIM].vld && ctl_c[DIM].fetch) begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (req_ready) begin
          k_nxt = k_r + KW'(1);
          if (k_r == KW'(DIM - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    inj_addr_r <= inj_addr_nxt;
    feed_r     <= feed_nxt;
    k_r        <= k_nxt;
    empty_r    <= empty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      inj_ctl_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      inj_ctl_r <= inj_ctl_nxt;
    end
  end

  always_comb begin
    req.vld     = (state_r == S_EMIT);
    req.comp    = CompW'(k_r);
    req.diff    = diffs[k_r];
    req.nearest = empty_r ? '0 : IdxW'(best_idx);
    req.empty   = empty_r;
    req.last    = (k_r == KW'(DIM - 1));
  end

  nrpa_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .req_ready  (req_ready),
    .gain       (gain_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/nrpa_cell.sv =====
// One search cell: holds one axis of every reference point and of the query.
// Depends on nrpa_pkg; chained once per axis by the top level.
module nrpa_cell #(
  parameter int DEPTH = 256,
  parameter int IW    = 8,
  parameter int SW    = 50
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [IW-1:0]                        wr_addr,
  input  logic signed [nrpa_pkg::CoordW-1:0]   wr_data,
  input  logic                                 q_en,
  input  nrpa_pkg::ctl_t                       ctl_i,
  input  logic [IW-1:0]                        addr_i,
  input  logic [SW-1:0]                        sum_i,
  output nrpa_pkg::ctl_t                       ctl_o,
  output logic [IW-1:0]                        addr_o,
  output logic [SW-1:0]                        sum_o,
  output logic signed [nrpa_pkg::DiffW-1:0]    diff_o
);
  import nrpa_pkg::*;

  logic signed [CoordW-1:0] mem [DEPTH];
  logic signed [CoordW-1:0] rd_r;
  logic signed [CoordW-1:0] q_r;
  logic signed [DiffW-1:0]  hold_r;
  logic [SqW-1:0]           sq_r;

  ctl_t          a_ctl_r, b_ctl_r, c_ctl_r;
  logic [IW-1:0] a_addr_r, b_addr_r, c_addr_r;
  logic [SW-1:0] a_sum_r, b_sum_r, c_sum_r;

  logic signed [DiffW-1:0]   diff;
  logic signed [2*DiffW-1:0] sq_full;

  assign diff    = DiffW'(rd_r) - DiffW'(q_r);
  assign sq_full = (2*DiffW)'(diff) * (2*DiffW)'(diff);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[addr_i];
  end

  always_ff @(posedge clk) begin
    if (q_en) begin
      q_r <= wr_data;
    end
    if (a_ctl_r.vld && a_ctl_r.fetch) begin
      hold_r <= diff;
    end
    a_addr_r <= addr_i;
    a_sum_r  <= sum_i;
    b_addr_r <= a_addr_r;
    b_sum_r  <= a_sum_r;
    sq_r     <= sq_full[SqW-1:0];
    c_addr_r <= b_addr_r;
    c_sum_r  <= b_sum_r + SW'(sq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
      c_ctl_r <= '0;
    end else begin
      a_ctl_r <= ctl_i;
      b_ctl_r <= a_ctl_r;
      c_ctl_r <= b_ctl_r;
    end
  end

  assign ctl_o  = c_ctl_r;
  assign addr_o = c_addr_r;
  assign sum_o  = c_sum_r;
  assign diff_o = hold_r;

endmodule

// ===== sv/nrpa_best.sv =====
// Tracker at the end of the cell chain that keeps the smallest distance seen.
// Depends on nrpa_pkg for the token markers.
module nrpa_best #(
  parameter int IW = 8,
  parameter int SW = 50
) (
  input  logic           clk,
  input  logic           rst_n,
  input  nrpa_pkg::ctl_t ctl_i,
  input  logic [IW-1:0]  addr_i,
  input  logic [SW-1:0]  sum_i,
  output logic [IW-1:0]  best_idx_o,
  output logic           done_o
);
  import nrpa_pkg::*;

  logic [SW-1:0] best_sum_r;
  logic [IW-1:0] best_idx_r;
  logic          done_r;
  logic          take;

  // The scan always starts at point zero, and only a strictly smaller
  // distance replaces the holder, so the lowest index wins a tie.
  assign take = ctl_i.vld && !ctl_i.fetch && ((addr_i == '0) || (sum_i < best_sum_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_sum_r <= sum_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_idx_r <= '0;
      done_r     <= 1'b0;
    end else begin
      if (take) begin
        best_idx_r <= addr_i;
      end
      done_r <= ctl_i.vld && !ctl_i.fetch && ctl_i.last;
    end
  end

  assign best_idx_o = best_idx_r;
  assign done_o     = done_r;

endmodule

// ===== sv/nrpa_emit.sv =====
// Result unit: scales one axis difference by the gain, rounds, saturates and
// holds the result in the output register. Depends on nrpa_pkg.
module nrpa_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nrpa_pkg::emit_req_t                 req,
  output logic                                req_ready,
  input  logic signed [nrpa_pkg::GainW-1:0]   gain,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [39:0]                         out_tdata,  // out_component, attract_value, nearest_index
  output logic                                out_tuser,  // table_empty
  output logic                                out_tlast   // last_result
);
  import nrpa_pkg::*;

  logic                    p_vld_r;
  logic signed [ProdW-1:0] p_prod_r;
  logic [CompW-1:0]        p_comp_r;
  logic [IdxW-1:0]         p_near_r;
  logic                    p_empty_r;
  logic                    p_last_r;

  logic                     o_vld_r;
  logic [CompW-1:0]         o_comp_r;
  logic signed [CoordW-1:0] o_val_r;
  logic [IdxW-1:0]          o_near_r;
  logic                     o_empty_r;
  logic                     o_last_r;

  logic                      o_free;
  logic                      p_move;
  logic                      p_load;
  logic signed [ProdW:0]     rsum;
  logic signed [ProdW-8:0]   rsh;
  logic signed [CoordW-1:0]  sat_val;

  assign o_free    = !o_vld_r || out_tready;
  assign p_move    = p_vld_r && o_free;
  assign req_ready = !p_vld_r || p_move;
  assign p_load    = req.vld && req_ready;

  // Adding half an LSB before the arithmetic shift rounds halves upwards.
  assign rsum = (ProdW+1)'(p_prod_r) + (ProdW+1)'(128);
  assign rsh  = rsum[ProdW:8];

  always_comb begin
    if (p_empty_r) begin
      sat_val = '0;
    end else if (rsh > (ProdW-7)'(SAT_HI)) begin
      sat_val = SAT_HI;
    end else if (rsh < (ProdW-7)'(SAT_LO)) begin
      sat_val = SAT_LO;
    end else begin
      sat_val = rsh[CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_prod_r  <= ProdW'(req.diff) * ProdW'(gain);
      p_comp_r  <= req.comp;
      p_near_r  <= req.nearest;
      p_empty_r <= req.empty;
      p_last_r  <= req.last;
    end
    if (p_move) begin
      o_comp_r  <= p_comp_r;
      o_val_r   <= sat_val;
      o_near_r  <= p_near_r;
      o_empty_r <= p_empty_r;
      o_last_r  <= p_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (p_load) begin
        p_vld_r <= 1'b1;
      end else if (p_move) begin
        p_vld_r <= 1'b0;
      end
      if (p_move) begin
        o_vld_r <= 1'b1;
      end else if (out_tready) begin
        o_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {5'b0, o_near_r, o_val_r, o_comp_r};
  assign out_tuser  = o_empty_r;
  assign out_tlast  = o_last_r;

endmodule
